>>> rtl/rrg_pkg.sv
// Shared constants, register codes, width helpers and flag types for the refraction ray generator.
package rrg_pkg;

  localparam int DIR_FRAC_BITS_DEF = 14;
  localparam int DIR_W = 16;
  localparam int POS_W = 32;
  localparam int CFG_W = 16;

  localparam logic [CFG_W-1:0] MATERIAL_INDEX_RST = 16'd21299;
  localparam logic [CFG_W-1:0] SURFACE_OFFSET_RST = 16'd66;

  typedef enum logic [0:0] {
    CFG_MATERIAL_INDEX = 1'b0,
    CFG_SURFACE_OFFSET = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic tir;
    logic exiting;
  } ray_flags_t;

  // width of d - m*dm
  function automatic int v_width(int f);
    return ((34 - f > 16) ? 34 - f : 16) + 1;
  endfunction

  // width of rounded eta squared
  function automatic int e2_width(int f);
    return 33 - f;
  endfunction

  // width of one - dm^2
  function automatic int diff_width(int f);
    return ((2 * f + 2 > 33) ? 2 * f + 2 : 33) + 1;
  endfunction

  // width of rounded one - dm^2
  function automatic int s_width(int f);
    return diff_width(f) - f + 1;
  endfunction

  // width of k
  function automatic int k_width(int f);
    int p;
    p = e2_width(f) + s_width(f) + 1;
    return ((p > 2 * f + 2) ? p : 2 * f + 2) + 1;
  endfunction

  // bits of the square root of k
  function automatic int root_width(int f);
    return (k_width(f) + 1) / 2;
  endfunction

endpackage

>>> rtl/refraction_ray_generator.sv
// Top level of the refraction ray generator: config registers, pipeline and output skid.
//
// Input stream (s_*): one transaction per hit carries the incident direction, the
// unit surface normal and the hit point. Output stream (m_*): one transaction per
// hit carries the refracted ray (origin and direction) and two flags in m_tuser.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 material index,
// 1 surface offset) at the clock edge; write only while no ray is in flight.
//
// Throughput is one ray per cycle while s_tready is high. A ray passes the front
// pipeline, then the square root pipeline of R = root_width(DIR_FRAC_BITS) stages
// (R = 21 at 14 fraction bits), then the back pipeline and the output register.
//
// Writing the material index starts a bit-serial divider for 1/index; s_tready stays low
// while it runs. Reset (rst, synchronous) restores both registers, empties the pipeline
// and runs that divider once, so s_tready stays low until it finishes.
//
// When m_tready is low the finished ray holds in the output register and the next
// one drops into a skid register; only when that is full does the whole pipeline
// hold. s_tready falls then and while the divider runs. No ray is lost or repeated.
module refraction_ray_generator import rrg_pkg::*; #(
  parameter int DIR_FRAC_BITS = DIR_FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // dir_x, dir_y, dir_z, normal_x, normal_y, normal_z, hit_x, hit_y, hit_z
  input  logic [191:0]     s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // origin_x, origin_y, origin_z, out_dir_x, out_dir_y, out_dir_z
  output logic [143:0]     m_tdata,
  // total_internal, exiting
  output logic [1:0]       m_tuser,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int VW  = v_width(DIR_FRAC_BITS);
  localparam int KW  = k_width(DIR_FRAC_BITS);
  localparam int RW  = root_width(DIR_FRAC_BITS);
  localparam int XW  = 2 * RW;
  localparam int PLW = 2 + 3 * VW + 3 * (DIR_W + 1) + CFG_W + 3 * POS_W;

  logic [CFG_W-1:0] material_index;
  logic [CFG_W-1:0] surface_offset;
  logic [CFG_W-1:0] eta_enter;
  logic             div_busy;
  logic             run;

  logic signed [DIR_W-1:0] d_in [3];
  logic signed [DIR_W-1:0] n_in [3];
  logic signed [POS_W-1:0] h_in [3];

  logic                    f_valid;
  ray_flags_t              f_flags;
  logic signed [KW-1:0]    f_k;
  logic signed [VW-1:0]    f_v [3];
  logic signed [DIR_W:0]   f_m [3];
  logic [CFG_W-1:0]        f_eta;
  logic signed [POS_W-1:0] f_org [3];
  logic [XW-1:0]           sq_x;
  logic [PLW-1:0]          pay_in;
  logic [PLW-1:0]          pay_out;

  logic                    q_valid;
  logic [RW-1:0]           q_root;
  ray_flags_t              q_flags;
  logic signed [VW-1:0]    q_v [3];
  logic signed [DIR_W:0]   q_m [3];
  logic [CFG_W-1:0]        q_eta;
  logic signed [POS_W-1:0] q_org [3];

  logic                    b_valid;
  ray_flags_t              b_flags;
  logic signed [POS_W-1:0] b_org [3];
  logic signed [DIR_W-1:0] b_dir [3];
  logic [145:0]            b_word;

  logic [145:0]            out_word;
  logic [145:0]            skid_word;
  logic                    skid_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      material_index <= MATERIAL_INDEX_RST;
      surface_offset <= SURFACE_OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_MATERIAL_INDEX: material_index <= cfg_data;
        CFG_SURFACE_OFFSET: surface_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  rrg_eta_div #(.DIR_FRAC_BITS(DIR_FRAC_BITS)) u_eta_div (
    .clk   (clk),
    .rst   (rst),
    .start (cfg_we && cfg_reg_t'(cfg_index) == CFG_MATERIAL_INDEX),
    .index (cfg_data),
    .busy  (div_busy),
    .eta   (eta_enter)
  );

  // the pipeline advances whenever the skid register is free
  assign run      = !skid_valid;
  assign s_tready = run && !div_busy;

  assign d_in[0] = s_tdata[15:0];
  assign d_in[1] = s_tdata[31:16];
  assign d_in[2] = s_tdata[47:32];
  assign n_in[0] = s_tdata[63:48];
  assign n_in[1] = s_tdata[79:64];
  assign n_in[2] = s_tdata[95:80];
  assign h_in[0] = s_tdata[127:96];
  assign h_in[1] = s_tdata[159:128];
  assign h_in[2] = s_tdata[191:160];

  rrg_front #(.DIR_FRAC_BITS(DIR_FRAC_BITS)) u_front (
    .clk            (clk),
    .rst            (rst),
    .run            (run),
    .in_valid       (s_tvalid && s_tready),
    .d_in           (d_in),
    .n_in           (n_in),
    .h_in           (h_in),
    .material_index (material_index),
    .eta_enter      (eta_enter),
    .surface_offset (surface_offset),
    .out_valid      (f_valid),
    .flags          (f_flags),
    .k              (f_k),
    .v              (f_v),
    .m              (f_m),
    .eta            (f_eta),
    .org            (f_org)
  );

  // k is positive unless the ray is reflected; the root is unused then
  assign sq_x   = f_flags.tir ? '0 : XW'(f_k);
  assign pay_in = {f_flags, f_v[0], f_v[1], f_v[2], f_m[0], f_m[1], f_m[2], f_eta,
                   f_org[0], f_org[1], f_org[2]};

  rrg_isqrt #(.RW(RW), .PLW(PLW)) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .run       (run),
    .in_valid  (f_valid),
    .x         (sq_x),
    .pay_in    (pay_in),
    .out_valid (q_valid),
    .root      (q_root),
    .pay_out   (pay_out)
  );

  assign {q_flags, q_v[0], q_v[1], q_v[2], q_m[0], q_m[1], q_m[2], q_eta,
          q_org[0], q_org[1], q_org[2]} = pay_out;

  rrg_back #(.DIR_FRAC_BITS(DIR_FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .run       (run),
    .in_valid  (q_valid),
    .flags_in  (q_flags),
    .sq        (q_root),
    .v         (q_v),
    .m         (q_m),
    .eta       (q_eta),
    .org_in    (q_org),
    .out_valid (b_valid),
    .flags     (b_flags),
    .org       (b_org),
    .dir       (b_dir)
  );

  assign b_word = {b_flags.exiting, b_flags.tir, b_dir[2], b_dir[1], b_dir[0],
                   b_org[2], b_org[1], b_org[0]};

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !m_tvalid) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= run && b_valid;
      end
    end else if (run && b_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !m_tvalid) begin
      out_word <= skid_valid ? skid_word : b_word;
    end else if (run && b_valid) begin
      skid_word <= b_word;
    end
  end

  assign m_tdata = out_word[143:0];
  assign m_tuser = out_word[145:144];

`ifndef SYNTH
  // a held skid entry always sits behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid holds a ray while the output is empty");

  // no ray enters while 1/index is being recomputed
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> !div_busy)
    else $error("ray accepted while the eta divider runs");

  // a full skid entry stalls the whole pipeline
  a_skid_stalls: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !s_tready)
    else $error("input accepted with a full skid entry");

  // a reflected ray carries an all-zero body
  a_tir_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
    else $error("reflected ray with nonzero origin or direction");
`endif

endmodule

>>> rtl/rrg_eta_div.sv
// Bit-serial divider producing eta = round(2^(2F) / index) for rays entering the material.
module rrg_eta_div import rrg_pkg::*; #(
  parameter int DIR_FRAC_BITS = DIR_FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [CFG_W-1:0] index,
  output logic             busy,
  output logic [CFG_W-1:0] eta
);

  localparam int NW = 2 * DIR_FRAC_BITS + 1;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0]    num;
  logic [NW-1:0]    quo;
  logic [CFG_W-1:0] rem;
  logic [CFG_W-1:0] dvs;
  logic [CW-1:0]    cnt;
  logic [CFG_W:0]   rem_sh;
  logic             fits;

  function automatic logic [NW-1:0] dividend(logic [CFG_W-1:0] idx);
    return (NW'(1) << (2 * DIR_FRAC_BITS)) + NW'(idx >> 1);
  endfunction

  assign rem_sh = {rem, num[NW-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      cnt  <= '0;
      num  <= dividend(MATERIAL_INDEX_RST);
      dvs  <= MATERIAL_INDEX_RST;
      rem  <= '0;
      quo  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      num  <= dividend(index);
      dvs  <= index;
      rem  <= '0;
      quo  <= '0;
    end else if (busy) begin
      rem  <= fits ? CFG_W'(rem_sh - {1'b0, dvs}) : CFG_W'(rem_sh);
      quo  <= {quo[NW-2:0], fits};
      num  <= num << 1;
      cnt  <= cnt + 1'b1;
      if (cnt == CW'(NW - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // saturate; a zero index divides to all ones and lands here too
  assign eta = (quo > NW'(16'hFFFF)) ? 16'hFFFF : quo[CFG_W-1:0];

endmodule

>>> rtl/rrg_front.sv
// Front pipeline: dot product, case select, products, rounding and k (five stages).
module rrg_front import rrg_pkg::*; #(
  parameter int DIR_FRAC_BITS = DIR_FRAC_BITS_DEF,
  localparam int F  = DIR_FRAC_BITS,
  localparam int VW = v_width(DIR_FRAC_BITS),
  localparam int KW = k_width(DIR_FRAC_BITS)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    run,
  input  logic                    in_valid,
  input  logic signed [DIR_W-1:0] d_in [3],
  input  logic signed [DIR_W-1:0] n_in [3],
  input  logic signed [POS_W-1:0] h_in [3],
  input  logic [CFG_W-1:0]        material_index,
  input  logic [CFG_W-1:0]        eta_enter,
  input  logic [CFG_W-1:0]        surface_offset,
  output logic                    out_valid,
  output ray_flags_t              flags,
  output logic signed [KW-1:0]    k,
  output logic signed [VW-1:0]    v [3],
  output logic signed [DIR_W:0]   m [3],
  output logic [CFG_W-1:0]        eta,
  output logic signed [POS_W-1:0] org [3]
);

  localparam int E2W = e2_width(DIR_FRAC_BITS);
  localparam int DW  = diff_width(DIR_FRAC_BITS);
  localparam int SW  = s_width(DIR_FRAC_BITS);
  localparam logic signed [34:0] HALF35 = 35'sd1 <<< (F - 1);
  localparam logic signed [DW-1:0] ONE_D = DW'(1) <<< (2 * F);
  localparam logic signed [DW-1:0] HALF_D = DW'(1) <<< (F - 1);
  localparam logic signed [KW-1:0] ONE_K = KW'(1) <<< (2 * F);

  logic [4:0] vld;

  // stage 1
  logic signed [DIR_W-1:0] d1 [3];
  logic signed [DIR_W-1:0] n1 [3];
  logic signed [POS_W-1:0] h1 [3];
  logic signed [31:0]      p1 [3];
  // stage 2
  logic signed [DIR_W-1:0] d2 [3];
  logic signed [DIR_W:0]   m2 [3];
  logic signed [POS_W-1:0] h2 [3];
  logic signed [DIR_W-1:0] dm2;
  logic [CFG_W-1:0]        eta2;
  logic                    ex2;
  // stage 3
  logic signed [DIR_W-1:0] d3 [3];
  logic signed [DIR_W:0]   m3 [3];
  logic signed [POS_W-1:0] h3 [3];
  logic signed [32:0]      mdm3 [3];
  logic signed [33:0]      mo3 [3];
  logic signed [31:0]      dmsq3;
  logic [31:0]             etasq3;
  logic [CFG_W-1:0]        eta3;
  logic                    ex3;
  // stage 4
  logic signed [VW-1:0]    v4 [3];
  logic signed [DIR_W:0]   m4 [3];
  logic signed [POS_W-1:0] org4 [3];
  logic signed [SW-1:0]    s4;
  logic [E2W-1:0]          e24;
  logic [CFG_W-1:0]        eta4;
  logic                    ex4;

  // combinational stage results
  logic signed [33:0]      c_sum;
  logic                    ex_c;
  logic signed [34:0]      dm_raw;
  logic signed [34:0]      dm_rnd;
  logic signed [DIR_W-1:0] dm_c;
  logic signed [DIR_W:0]   m_c [3];
  logic signed [DW-1:0]    diff_c;
  logic signed [DW-1:0]    s_full;
  logic [32:0]             e2_full;
  logic signed [34:0]      mr_c [3];
  logic signed [34:0]      pr_c [3];
  logic signed [34:0]      vf_c [3];
  logic signed [34:0]      of_c [3];
  logic signed [POS_W-1:0] org_c [3];
  logic signed [E2W+SW:0]  prod_c;

  always_comb begin
    c_sum = 34'(p1[0]) + 34'(p1[1]) + 34'(p1[2]);
    ex_c  = c_sum > 34'sd0;
    // d.m is -c when the normal flips
    dm_raw = ex_c ? -35'(c_sum) : 35'(c_sum);
    dm_rnd = (dm_raw + HALF35) >>> F;
    if (dm_rnd > 35'sd32767) begin
      dm_c = 16'sh7FFF;
    end else if (dm_rnd < -35'sd32768) begin
      dm_c = 16'sh8000;
    end else begin
      dm_c = dm_rnd[DIR_W-1:0];
    end
    for (int i = 0; i < 3; i++) begin
      m_c[i] = ex_c ? -17'(n1[i]) : 17'(n1[i]);
    end

    diff_c  = ONE_D - DW'(dmsq3);
    s_full  = (diff_c + HALF_D) >>> F;
    e2_full = ({1'b0, etasq3} + (33'd1 << (F - 1))) >> F;
    for (int i = 0; i < 3; i++) begin
      mr_c[i] = (35'(mdm3[i]) + HALF35) >>> F;
      pr_c[i] = (35'(mo3[i]) + HALF35) >>> F;
      vf_c[i] = 35'(d3[i]) - mr_c[i];
      of_c[i] = 35'(h3[i]) - pr_c[i];
      if (of_c[i] > 35'sd2147483647) begin
        org_c[i] = 32'sh7FFFFFFF;
      end else if (of_c[i] < -35'sd2147483648) begin
        org_c[i] = 32'sh80000000;
      end else begin
        org_c[i] = of_c[i][POS_W-1:0];
      end
    end

    prod_c = $signed({1'b0, e24}) * s4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (run) begin
      vld <= {vld[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      for (int i = 0; i < 3; i++) begin
        d1[i] <= d_in[i];
        n1[i] <= n_in[i];
        h1[i] <= h_in[i];
        p1[i] <= d_in[i] * n_in[i];

        d2[i] <= d1[i];
        m2[i] <= m_c[i];
        h2[i] <= h1[i];

        d3[i]   <= d2[i];
        m3[i]   <= m2[i];
        h3[i]   <= h2[i];
        mdm3[i] <= m2[i] * dm2;
        mo3[i]  <= m2[i] * $signed({1'b0, surface_offset});

        v4[i]   <= VW'(vf_c[i]);
        m4[i]   <= m3[i];
        org4[i] <= org_c[i];

        v[i]   <= v4[i];
        m[i]   <= m4[i];
        org[i] <= org4[i];
      end
      dm2  <= dm_c;
      ex2  <= ex_c;
      eta2 <= ex_c ? material_index : eta_enter;

      dmsq3  <= dm2 * dm2;
      etasq3 <= eta2 * eta2;
      eta3   <= eta2;
      ex3    <= ex2;

      s4   <= SW'(s_full);
      e24  <= E2W'(e2_full);
      eta4 <= eta3;
      ex4  <= ex3;

      k             <= ONE_K - KW'(prod_c);
      eta           <= eta4;
      flags.exiting <= ex4;
      flags.tir     <= (ONE_K - KW'(prod_c)) <= KW'(0);
    end
  end

  assign out_valid = vld[4];

endmodule

>>> rtl/rrg_isqrt.sv
// Pipelined floor square root, one result bit per stage, with a payload carried alongside.
module rrg_isqrt #(
  parameter int RW  = 21,
  parameter int PLW = 8,
  localparam int XW = 2 * RW
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           run,
  input  logic           in_valid,
  input  logic [XW-1:0]  x,
  input  logic [PLW-1:0] pay_in,
  output logic           out_valid,
  output logic [RW-1:0]  root,
  output logic [PLW-1:0] pay_out
);

  logic [XW-1:0]  rem_q  [RW];
  logic [RW-1:0]  root_q [RW];
  logic [PLW-1:0] pay_q  [RW];
  logic [RW-1:0]  vld_q;

  for (genvar j = 0; j < RW; j++) begin : g_stage
    localparam int B = RW - 1 - j;
    logic [XW-1:0]  rem_p;
    logic [RW-1:0]  root_p;
    logic [PLW-1:0] pay_p;
    logic           vld_p;
    logic [XW:0]    trial;
    logic           ge;

    if (j == 0) begin : g_first
      assign rem_p  = x;
      assign root_p = '0;
      assign pay_p  = pay_in;
      assign vld_p  = in_valid;
    end else begin : g_next
      assign rem_p  = rem_q[j-1];
      assign root_p = root_q[j-1];
      assign pay_p  = pay_q[j-1];
      assign vld_p  = vld_q[j-1];
    end

    // (R + 2^B)^2 - R^2
    assign trial = ((XW + 1)'(root_p) << (B + 1)) | ((XW + 1)'(1) << (2 * B));
    assign ge    = {1'b0, rem_p} >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[j] <= 1'b0;
      end else if (run) begin
        vld_q[j] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (run) begin
        rem_q[j]  <= ge ? XW'({1'b0, rem_p} - trial) : rem_p;
        root_q[j] <= ge ? (root_p | (RW'(1) << B)) : root_p;
        pay_q[j]  <= pay_p;
      end
    end
  end

  assign out_valid = vld_q[RW-1];
  assign root      = root_q[RW-1];
  assign pay_out   = pay_q[RW-1];

endmodule

>>> rtl/rrg_back.sv
// Back pipeline: eta*v - m*sqrt(k), then round, saturate and zero on total internal reflection.
module rrg_back import rrg_pkg::*; #(
  parameter int DIR_FRAC_BITS = DIR_FRAC_BITS_DEF,
  localparam int F  = DIR_FRAC_BITS,
  localparam int VW = v_width(DIR_FRAC_BITS),
  localparam int RW = root_width(DIR_FRAC_BITS)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    run,
  input  logic                    in_valid,
  input  ray_flags_t              flags_in,
  input  logic [RW-1:0]           sq,
  input  logic signed [VW-1:0]    v [3],
  input  logic signed [DIR_W:0]   m [3],
  input  logic [CFG_W-1:0]        eta,
  input  logic signed [POS_W-1:0] org_in [3],
  output logic                    out_valid,
  output ray_flags_t              flags,
  output logic signed [POS_W-1:0] org [3],
  output logic signed [DIR_W-1:0] dir [3]
);

  localparam int PEW = VW + 17;
  localparam int PMW = RW + 18;
  localparam int TW  = ((PEW > PMW) ? PEW : PMW) + 1;
  localparam logic signed [TW-1:0] HALF_T = TW'(1) <<< (F - 1);

  logic signed [PEW-1:0]   pe [3];
  logic signed [PMW-1:0]   pm [3];
  logic signed [POS_W-1:0] org_a [3];
  ray_flags_t              flags_a;
  logic [1:0]              vld;
  logic signed [TW-1:0]    t_c [3];
  logic signed [DIR_W-1:0] dir_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t_c[i] = (TW'(pe[i]) - TW'(pm[i]) + HALF_T) >>> F;
      if (t_c[i] > TW'(32767)) begin
        dir_c[i] = 16'sh7FFF;
      end else if (t_c[i] < -TW'(32768)) begin
        dir_c[i] = 16'sh8000;
      end else begin
        dir_c[i] = t_c[i][DIR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (run) begin
      vld <= {vld[0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      flags_a <= flags_in;
      flags   <= flags_a;
      for (int i = 0; i < 3; i++) begin
        pe[i]    <= $signed({1'b0, eta}) * v[i];
        pm[i]    <= m[i] * $signed({1'b0, sq});
        org_a[i] <= org_in[i];
        org[i]   <= flags_a.tir ? '0 : org_a[i];
        dir[i]   <= flags_a.tir ? '0 : dir_c[i];
      end
    end
  end

  assign out_valid = vld[1];

endmodule

>>> tb/tb.sv
// Self-checking testbench for the refraction ray generator.
`timescale 1ns / 1ps

module tb;
  import rrg_pkg::*;

  localparam int FB = 14;
  localparam int LATENCY = 28;
  localparam int DRAIN_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic signed [31:0] hz, hy, hx;
    logic signed [15:0] nz, ny, nx;
    logic signed [15:0] dz, dy, dx;
  } hit_t;

  typedef struct packed {
    logic signed [15:0] rdz, rdy, rdx;
    logic signed [31:0] oz, oy, ox;
  } ray_t;

  typedef struct {
    logic tir;
    logic exiting;
    ray_t ray;
  } ray_result_t;

  typedef struct {
    hit_t        hit;
    logic        typed;   // row carries its own expected result
    ray_result_t want;
  } stim_row_t;

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [191:0] s_tdata;
  logic [143:0] m_tdata;
  logic [1:0] m_tuser;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  refraction_ray_generator DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // model copy of the configuration registers
  logic [15:0] index_reg, offset_reg;

  ray_result_t pending_rays[$];
  int errors = 0;
  int stall_pct = 0;      // receiver idle percentage
  int gap_pct = 0;        // sender idle percentage
  int idle_cycles = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic longint round_sh(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint isqrt(longint v);
    longint r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Snell refraction in fixed point, one hit in, one ray out.
  function automatic ray_result_t refract(hit_t h);
    ray_result_t res;
    longint d[3], m[3], p[3], c, dm, eta, one, s, e2, k, sq, v, t, push;
    d[0] = h.dx; d[1] = h.dy; d[2] = h.dz;
    m[0] = h.nx; m[1] = h.ny; m[2] = h.nz;
    p[0] = h.hx; p[1] = h.hy; p[2] = h.hz;
    c = 0;
    for (int i = 0; i < 3; i++) c += d[i] * m[i];
    res.exiting = c > 0;
    if (res.exiting) begin
      for (int i = 0; i < 3; i++) m[i] = -m[i];
      eta = index_reg;
    end else if (index_reg == 0) begin
      eta = 65535;
    end else begin
      eta = ((longint'(1) << (2 * FB)) + index_reg / 2) / index_reg;
      if (eta > 65535) eta = 65535;
    end
    dm = 0;
    for (int i = 0; i < 3; i++) dm += d[i] * m[i];
    dm = sat(round_sh(dm, FB), -32768, 32767);
    one = longint'(1) << (2 * FB);
    s = round_sh(one - dm * dm, FB);
    e2 = round_sh(eta * eta, FB);
    k = one - e2 * s;
    res.tir = k <= 0;
    res.ray = '0;
    if (!res.tir) begin
      sq = isqrt(k);
      for (int i = 0; i < 3; i++) begin
        v = d[i] - round_sh(m[i] * dm, FB);
        t = eta * v - m[i] * sq;
        push = round_sh(m[i] * longint'(offset_reg), FB);
        case (i)
          0: begin
            res.ray.rdx = 16'(sat(round_sh(t, FB), -32768, 32767));
            res.ray.ox = 32'(sat(p[i] - push, -64'sd2147483648, 64'sd2147483647));
          end
          1: begin
            res.ray.rdy = 16'(sat(round_sh(t, FB), -32768, 32767));
            res.ray.oy = 32'(sat(p[i] - push, -64'sd2147483648, 64'sd2147483647));
          end
          default: begin
            res.ray.rdz = 16'(sat(round_sh(t, FB), -32768, 32767));
            res.ray.oz = 32'(sat(p[i] - push, -64'sd2147483648, 64'sd2147483647));
          end
        endcase
      end
    end
    return res;
  endfunction

  // Receiver: random back-pressure, compare each accepted ray with the oldest one due.
  always @(negedge clk) begin
    m_tready <= rst ? 1'b0 : ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    ray_result_t exp_ray;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_rays.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected ray %h flags %b", m_tdata, m_tuser);
      end else begin
        exp_ray = pending_rays.pop_front();
        if (m_tdata !== exp_ray.ray || m_tuser[0] !== exp_ray.tir
            || m_tuser[1] !== exp_ray.exiting) begin
          errors++;
          if (errors <= 10)
            $display("ray mismatch: want %h tir %b exit %b, got %h tuser %b",
                     exp_ray.ray, exp_ray.tir, exp_ray.exiting, m_tdata, m_tuser);
        end
      end
    end
  end

  // Watchdog: count cycles in which no transaction moves on either side.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("refraction_ray_generator verification failed");
      $finish;
    end
  end

  // Push one hit: idle for a random gap, then hold tvalid until the handshake.
  task automatic send_hit(hit_t h, ray_result_t want, bit typed);
    ray_result_t pred;
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    pred = refract(h);
    if (typed && (pred.tir !== want.tir || pred.exiting !== want.exiting
        || pred.ray !== want.ray)) begin
      // hand-written row disagrees with predictor; trust the hand value
      pred = want;
    end
    s_tdata <= h;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_rays.push_back(pred);
    @(negedge clk);
  endtask

  // Hold off until every ray due has come out, plus the pipeline depth.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_rays.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MATERIAL_INDEX) index_reg = val;
    else offset_reg = val;
    @(negedge clk);
  endtask

  function automatic logic signed [15:0] rnd_dir();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return $signed(16'($urandom_range(32768))) - 16'sd16384;
    endcase
  endfunction

  // Mostly unit-ish vectors built from random axis mixes, some raw noise.
  function automatic hit_t rnd_hit();
    hit_t h;
    h.dx = rnd_dir(); h.dy = rnd_dir(); h.dz = rnd_dir();
    h.nx = rnd_dir(); h.ny = rnd_dir(); h.nz = rnd_dir();
    if ($urandom_range(99) < 70) begin
      // unit normal along an axis, incident roughly normalized
      h.nx = 0; h.ny = 0; h.nz = 0;
      case ($urandom_range(5))
        0: h.nx = 16384; 1: h.nx = -16384; 2: h.ny = 16384;
        3: h.ny = -16384; 4: h.nz = 16384; default: h.nz = -16384;
      endcase
      h.dx = $signed(16'($urandom_range(18000))) - 16'sd9000;
      h.dy = $signed(16'($urandom_range(18000))) - 16'sd9000;
      h.dz = $signed(16'($urandom_range(32768))) - 16'sd16384;
    end
    h.hx = $urandom; h.hy = $urandom; h.hz = $urandom;
    if ($urandom_range(9) == 0) h.hx = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
    return h;
  endfunction

  stim_row_t dir_rows[$];

  function automatic stim_row_t row(logic signed [15:0] dx, dy, dz, nx, ny, nz,
                                    logic signed [31:0] hx, hy, hz);
    stim_row_t r;
    r.hit = '{hz: hz, hy: hy, hx: hx, nz: nz, ny: ny, nx: nx, dz: dz, dy: dy, dx: dx};
    r.typed = 0;
    r.want.tir = 0; r.want.exiting = 0; r.want.ray = '0;
    return r;
  endfunction

  initial begin
    stim_row_t r;
    int phase_n;
    rst = 1; s_tvalid = 0; s_tdata = '0;
    cfg_we = 0; cfg_index = CFG_MATERIAL_INDEX; cfg_data = '0;
    index_reg = MATERIAL_INDEX_RST;
    offset_reg = SURFACE_OFFSET_RST;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed rows: straight entry, exit, grazing, extremes, and TIR.
    // Straight-down entering ray: d=-z, n=+z -> dir passes unchanged, origin pushed below.
    r = row(0, 0, -16384, 0, 0, 16384, 0, 0, 0);
    r.typed = 1; r.want.ray.rdz = -16384; r.want.ray.oz = -66;
    dir_rows.push_back(r);
    dir_rows.push_back(row(0, 0, 16384, 0, 0, 16384, 100, -100, 7));       // exiting
    dir_rows.push_back(row(16384, 0, 0, 0, 0, 16384, 0, 0, 0));            // grazing
    // Shallow exit, beyond the critical angle: totally reflected, zero ray.
    r = row(16000, 0, 3000, 0, 0, 16384, 5, 5, 5);
    r.typed = 1; r.want.tir = 1; r.want.exiting = 1;
    dir_rows.push_back(r);
    dir_rows.push_back(row(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                           32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    dir_rows.push_back(row(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                           32'h80000000, 32'h80000000, 32'h80000000));
    dir_rows.push_back(row(16'sh8000, 16'sh7fff, 0, 16'sh7fff, 16'sh8000, 0,
                           32'h80000000, 32'h7fffffff, 0));
    dir_rows.push_back(row(0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(-11585, 0, -11585, 0, 0, 16384, 32'h7fffffff, 0, 32'h80000000));
    dir_rows.push_back(row(11585, 0, 11585, 0, 0, 16384, -1, 1, -1));
    dir_rows.push_back(row(3000, -4000, -15000, 0, 16384, 0, 65536, -65536, 0));
    dir_rows.push_back(row(-1, -1, -1, -1, -1, -1, -1, -1, -1));

    gap_pct = 34; stall_pct = 77;
    foreach (dir_rows[i]) send_hit(dir_rows[i].hit, dir_rows[i].want, dir_rows[i].typed);
    drain();

    // Random phases over several settings; the sender pauses for a full drain at each change.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(CFG_MATERIAL_INDEX, 16'd4096); write_reg(CFG_SURFACE_OFFSET, 0); end
        1: begin write_reg(CFG_MATERIAL_INDEX, 16'hffff); write_reg(CFG_SURFACE_OFFSET, 16'hffff); end
        2: write_reg(CFG_MATERIAL_INDEX, 16'd0);
        3: write_reg(CFG_MATERIAL_INDEX, 16'd100);
        default: begin
          write_reg(CFG_MATERIAL_INDEX, 16'($urandom_range(65535, 4096)));
          write_reg(CFG_SURFACE_OFFSET, 16'($urandom));
        end
      endcase
      if (ph < 3) begin gap_pct = 34; stall_pct = 77; end
      else if (ph < 6) begin gap_pct = 77; stall_pct = 34; end
      else begin gap_pct = 0; stall_pct = 0; end
      phase_n = 250;
      for (int n = 0; n < phase_n; n++) send_hit(rnd_hit(), r.want, 0);
      drain();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && pending_rays.size() == 0)
      $display("refraction_ray_generator verification clean");
    else
      $display("refraction_ray_generator verification failed");
    $finish;
  end

endmodule
